/* rtl/core/jhm_pkg.sv */
// Shared types and constants for the joint histogram core.
// No dependencies; jhm_front, jhm_back and the top level refer to it by scoped names.
package jhm_pkg;

   // Operation codes of a request
   localparam logic [2:0] OP_ACCUMULATE = 3'd0;
   localparam logic [2:0] OP_VALUE_MARG = 3'd1;
   localparam logic [2:0] OP_GRAD_MARG  = 3'd2;
   localparam logic [2:0] OP_READ_CELL  = 3'd3;
   localparam logic [2:0] OP_TOTAL      = 3'd4;

   // Status codes of a response
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   localparam int BIN_IN_W    = 8;
   localparam int AMOUNT_W    = 32;
   localparam int COUNT_OUT_W = 48;

   typedef struct packed {
      logic [2:0]            operation;
      logic [BIN_IN_W-1:0]   value_bin;
      logic [BIN_IN_W-1:0]   grad_bin;
      logic [AMOUNT_W-1:0]   amount;
   } req_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] count_out;
      logic                   status;
   } rsp_type;

   // Decoded command kinds passed from front to back
   typedef enum logic [2:0] {
      CMD_ACC   = 3'd0,
      CMD_ROW   = 3'd1,
      CMD_COL   = 3'd2,
      CMD_CELL  = 3'd3,
      CMD_TOTAL = 3'd4,
      CMD_NOP   = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic                  bad;
      logic [BIN_IN_W-1:0]   value_bin;
      logic [BIN_IN_W-1:0]   grad_bin;
      logic [AMOUNT_W-1:0]   amount;
   } cmd_type;

endpackage

/* rtl/core/jhm_queue.sv */
// Small register-based FIFO used between front and back and on the response side.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module jhm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/jhm_front.sv */
// Front end: takes requests, range-checks the bins, decodes the operation
// and queues the resulting command. Uses jhm_pkg and jhm_queue.
module jhm_front #(
   parameter int BIN_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  jhm_pkg::req_type req_payload,
   output logic             req_full,
   input  logic             clearing,
   output logic             cmd_valid,
   output jhm_pkg::cmd_type cmd_data,
   input  logic             cmd_pop
);

   localparam logic [jhm_pkg::BIN_IN_W:0] BIN_LIMIT = (jhm_pkg::BIN_IN_W + 1)'(BIN_COUNT);

   jhm_pkg::cmd_type cmd_new;
   logic             v_ok, g_ok;
   logic             q_full, q_empty, q_push;

   assign v_ok = {1'b0, req_payload.value_bin} < BIN_LIMIT;
   assign g_ok = {1'b0, req_payload.grad_bin}  < BIN_LIMIT;

   // Classify the request
   always_comb begin
      cmd_new.value_bin = req_payload.value_bin;
      cmd_new.grad_bin  = req_payload.grad_bin;
      cmd_new.amount    = req_payload.amount;
      unique case (req_payload.operation)
         jhm_pkg::OP_ACCUMULATE: begin
            cmd_new.kind = jhm_pkg::CMD_ACC;
            cmd_new.bad  = !(v_ok && g_ok);
         end
         jhm_pkg::OP_VALUE_MARG: begin
            cmd_new.kind = jhm_pkg::CMD_ROW;
            cmd_new.bad  = !v_ok;
         end
         jhm_pkg::OP_GRAD_MARG: begin
            cmd_new.kind = jhm_pkg::CMD_COL;
            cmd_new.bad  = !g_ok;
         end
         jhm_pkg::OP_READ_CELL: begin
            cmd_new.kind = jhm_pkg::CMD_CELL;
            cmd_new.bad  = !(v_ok && g_ok);
         end
         jhm_pkg::OP_TOTAL: begin
            cmd_new.kind = jhm_pkg::CMD_TOTAL;
            cmd_new.bad  = 1'b0;
         end
         default: begin
            cmd_new.kind = jhm_pkg::CMD_NOP;
            cmd_new.bad  = 1'b0;
         end
      endcase
   end

   // No requests taken during the post-reset clearing sweep
   assign req_full  = q_full || clearing;
   assign q_push    = req_push && !req_full;
   assign cmd_valid = !q_empty;

   jhm_queue #(
      .WIDTH ($bits(jhm_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (cmd_new),
      .full      (q_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (q_empty)
   );

endmodule

/* rtl/core/jhm_back.sv */
// Back end: count memories, running marginals and the update sequencer.
// Uses jhm_pkg; fed by jhm_front, feeds the response queue.
module jhm_back #(
   parameter int BIN_COUNT   = 64,
   parameter int COUNT_WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  jhm_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output jhm_pkg::rsp_type rsp_data,
   output logic             clearing
);

   localparam int BIN_W  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int CELLS  = BIN_COUNT * BIN_COUNT;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SUM_W  = ((COUNT_WIDTH > jhm_pkg::AMOUNT_W) ? COUNT_WIDTH
                                                             : jhm_pkg::AMOUNT_W) + 1;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [BIN_W:0]    BIN_LIMIT = (BIN_W + 1)'(BIN_COUNT);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Saturating add of a request amount to a count
   function automatic count_type sat_add(input count_type a,
                                         input logic [jhm_pkg::AMOUNT_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s[SUM_W-1:COUNT_WIDTH] != '0) begin
         return '1;
      end
      return s[COUNT_WIDTH-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   jhm_pkg::cmd_type cmd_ff;
   logic [ADDR_W-1:0] cell_addr_ff;
   count_type        total_ff, total_in;

   count_type cell_mem [CELLS];
   count_type row_mem  [BIN_COUNT];
   count_type col_mem  [BIN_COUNT];
   count_type cell_rd_ff, row_rd_ff, col_rd_ff;

   logic [BIN_W-1:0]  rd_vb, rd_gb, ex_vb, ex_gb, clr_bin;
   logic [ADDR_W-1:0] cell_raddr;
   logic              exec_upd, clr_bin_ok;
   count_type         cell_new, row_new, col_new, total_new;
   logic              cell_we, sum_we;
   logic [ADDR_W-1:0] cell_waddr;
   logic [BIN_W-1:0]  row_waddr, col_waddr;
   count_type         cell_wdata, row_wdata, col_wdata;
   count_type         result;
   logic [63:0]       result_wide;

   // Read side: address from the head of the command queue
   assign rd_vb      = cmd_data.value_bin[BIN_W-1:0];
   assign rd_gb      = cmd_data.grad_bin[BIN_W-1:0];
   assign cell_raddr = ADDR_W'(32'(rd_vb) * BIN_COUNT + 32'(rd_gb));

   assign clearing = (state_ff == ST_CLEAR);
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid && !rsp_full;
   assign rsp_push = (state_ff == ST_EXEC);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Update arithmetic
   assign ex_vb     = cmd_ff.value_bin[BIN_W-1:0];
   assign ex_gb     = cmd_ff.grad_bin[BIN_W-1:0];
   assign exec_upd  = (state_ff == ST_EXEC) && (cmd_ff.kind == jhm_pkg::CMD_ACC) && !cmd_ff.bad;
   assign cell_new  = sat_add(cell_rd_ff, cmd_ff.amount);
   assign row_new   = sat_add(row_rd_ff,  cmd_ff.amount);
   assign col_new   = sat_add(col_rd_ff,  cmd_ff.amount);
   assign total_new = sat_add(total_ff,   cmd_ff.amount);
   assign total_in  = exec_upd ? total_new : total_ff;

   // Write side: clearing sweep or accumulate write-back
   assign clr_bin    = clr_ff[BIN_W-1:0];
   assign clr_bin_ok = {1'b0, clr_bin} < BIN_LIMIT;
   assign cell_we    = clearing || exec_upd;
   assign sum_we     = (clearing && clr_bin_ok) || exec_upd;
   assign cell_waddr = clearing ? clr_ff  : cell_addr_ff;
   assign row_waddr  = clearing ? clr_bin : ex_vb;
   assign col_waddr  = clearing ? clr_bin : ex_gb;
   assign cell_wdata = clearing ? '0 : cell_new;
   assign row_wdata  = clearing ? '0 : row_new;
   assign col_wdata  = clearing ? '0 : col_new;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem[rd_vb];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      col_rd_ff <= col_mem[rd_gb];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         total_ff <= total_in;
      end
   end

   // Command held for the execute cycle
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff       <= cmd_data;
         cell_addr_ff <= cell_raddr;
      end
   end

   // Response selection
   always_comb begin
      result = '0;
      if (!cmd_ff.bad) begin
         case (cmd_ff.kind)
            jhm_pkg::CMD_ACC:   result = cell_new;
            jhm_pkg::CMD_ROW:   result = row_rd_ff;
            jhm_pkg::CMD_COL:   result = col_rd_ff;
            jhm_pkg::CMD_CELL:  result = cell_rd_ff;
            jhm_pkg::CMD_TOTAL: result = total_ff;
            default:            result = '0;
         endcase
      end
      result_wide        = 64'(result);
      rsp_data.count_out = result_wide[jhm_pkg::COUNT_OUT_W-1:0];
      rsp_data.status    = cmd_ff.bad ? jhm_pkg::STATUS_BAD_INDEX : jhm_pkg::STATUS_OK;
   end

   // Every command taken yields exactly one response on the next cycle
   a_pop_then_push: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_push)
      else $error("command taken without a response");

   // The response queue is not full when a response is pushed
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into a full queue");

   // The grand total never decreases
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("grand total decreased");

   // No command is taken during the clearing sweep
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |=> !$past(cmd_pop))
      else $error("command taken while clearing");

endmodule

/* rtl/core/joint_histogram_with_marginals_core.sv */
// Top level of the joint value/gradient histogram with running marginals.
// Uses jhm_pkg, jhm_front, jhm_back and jhm_queue.
//
//   channel   ports                               direction
//   request   req_push, req_full, req_payload     in  (queue write side)
//   response  rsp_empty, rsp_pop, rsp_payload     out (queue read side)
//
// Each request passes the back end's idle and execute states: in idle it is
// taken and the cell, row and column memories are read; in execute they are
// updated and the response is posted; the back end takes no new request until then.
// After reset a clearing sweep over all BIN_COUNT*BIN_COUNT cells zeroes the memories;
// req_full stays high during the sweep. Up to two requests queue ahead of the back
// end and two responses behind it; a stalled response side stops the back end.
module joint_histogram_with_marginals_core #(
   parameter int BIN_COUNT   = 64,
   parameter int COUNT_WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  jhm_pkg::req_type req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jhm_pkg::rsp_type rsp_payload
);

   logic             clearing;
   logic             cmd_valid, cmd_pop;
   jhm_pkg::cmd_type cmd_data;
   logic             rsp_push, rsp_full;
   jhm_pkg::rsp_type rsp_data;

   jhm_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .clearing    (clearing),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   jhm_back #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .clearing  (clearing)
   );

   // Response queue decouples the back end from the consumer
   jhm_queue #(
      .WIDTH ($bits(jhm_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_payload),
      .empty     (rsp_empty)
   );

endmodule
